// ----- hw/rtl/fqca_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the queue arbiter.
`timescale 1ns / 1ps

package fqca_pkg;

   // Geometry of the per-input queues
   localparam int LANES      = 4;
   localparam int LANE_W     = 2;
   localparam int FIFO_DEPTH = 10;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int STORE_DEPTH = LANES * FIFO_DEPTH;
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int ID_W       = 8;

   // Operation codes of an input transaction
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Result event codes
   localparam logic [2:0] EV_QUEUED  = 3'd0;
   localparam logic [2:0] EV_DROP    = 3'd1;
   localparam logic [2:0] EV_REFUSED = 3'd2;
   localparam logic [2:0] EV_IDLE    = 3'd3;
   localparam logic [2:0] EV_GRANT   = 3'd4;
   localparam logic [2:0] EV_BUSY    = 3'd5;
   localparam logic [2:0] EV_RELEASE = 3'd6;

   // Configuration register indexes and reset values
   localparam logic       REG_HOLD    = 1'b0;
   localparam logic       REG_LIMIT   = 1'b1;
   localparam logic [7:0] HOLD_RESET  = 8'd3;
   localparam logic [7:0] LIMIT_RESET = 8'd50;

   // Controller to datapath commands
   typedef struct packed {
      logic take;    // latch the input transaction
      logic fetch;   // read the queue head for a grant
      logic commit;  // apply the update and load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic tick_grant;  // offered transaction is a tick that will grant
   } stat_type;

endpackage

// ----- hw/rtl/four_way_queue_crossing_arbiter.sv -----
// Top level: four-input arbiter with a ring queue of request ids per input.
//
//  Channel   Dir  Handshake              Payload
//  req_      in   req_valid/req_ready    req_op, req_lane
//  rsp_      out  rsp_valid/rsp_ready    event_res, req_id, req_lane, busy_res,
//                                        issued_count, served_count, done_flag
//  csr_      in   csr_valid/csr_ready    csr_index, csr_data
//
// Each transaction has an accept step that also issues the queue head read on the
// id store, and an execute step that updates state and loads the result register.
// The next transaction is accepted only once the execute step is over.
// A new transaction is accepted while a result waits; the execute step then
// holds until the result register frees up. csr_ready is always high.
// Reset is synchronous and clears queues, counters and resource state; the id
// store itself is not cleared.
`timescale 1ns / 1ps

module four_way_queue_crossing_arbiter
   import fqca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [LANE_W-1:0] req_lane,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_res,
   output logic [ID_W-1:0]   rsp_req_id,
   output logic [LANE_W-1:0] rsp_req_lane,
   output logic              rsp_busy_res,
   output logic [7:0]        rsp_issued_count,
   output logic [7:0]        rsp_served_count,
   output logic              rsp_done_flag,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data
);

   cmd_type  cmd;
   stat_type stat;

   fqca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fqca_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_lane         (req_lane),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_event_res    (rsp_event_res),
      .rsp_req_id       (rsp_req_id),
      .rsp_req_lane     (rsp_req_lane),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_issued_count (rsp_issued_count),
      .rsp_served_count (rsp_served_count),
      .rsp_done_flag    (rsp_done_flag)
   );

   // An accepted transaction occupies the execute step for the next cycle
   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted during execute step");

   // A new result appears only out of the execute step
   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result loaded outside execute step");

   // A release leaves the resource free, a grant leaves it busy
   a_release_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_RELEASE) |-> !rsp_busy_res)
      else $error("resource still busy after release");

   a_grant_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_GRANT) |-> rsp_busy_res)
      else $error("resource idle after grant");

endmodule

// ----- hw/rtl/fqca_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fqca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fqca_ctrl.sv -----
// Controller state machine: input handshake, execute step and result register valid.
`timescale 1ns / 1ps

module fqca_ctrl
   import fqca_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;
   logic commit;

   // Handshake decode
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign cmd.take   = accept;
   assign cmd.fetch  = accept && stat.tick_grant;
   assign cmd.commit = commit;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/fqca_dp.sv -----
// Datapath: queue pointers, id store, resource state, counters, config and result registers.
`timescale 1ns / 1ps

module fqca_dp
   import fqca_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_op,
   input  logic [LANE_W-1:0] req_lane,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [7:0]        csr_data,
   input  cmd_type           cmd,
   output stat_type          stat,
   output logic [2:0]        rsp_event_res,
   output logic [ID_W-1:0]   rsp_req_id,
   output logic [LANE_W-1:0] rsp_req_lane,
   output logic              rsp_busy_res,
   output logic [7:0]        rsp_issued_count,
   output logic [7:0]        rsp_served_count,
   output logic              rsp_done_flag
);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   // Configuration
   logic [7:0] hold_ticks_ff;
   logic [7:0] id_limit_ff;

   // Queue and resource state
   logic [PTR_W-1:0]  head_ff [LANES];
   logic [PTR_W-1:0]  head_in [LANES];
   logic [PTR_W-1:0]  tail_ff [LANES];
   logic [PTR_W-1:0]  tail_in [LANES];
   logic [CNT_W-1:0]  fill_ff [LANES];
   logic [CNT_W-1:0]  fill_in [LANES];
   logic [LANE_W-1:0] scan_ff;
   logic [LANE_W-1:0] scan_in;
   logic              occ_ff;
   logic              occ_in;
   logic [7:0]        ticks_ff;
   logic [7:0]        ticks_in;
   logic [ID_W-1:0]   act_id_ff;
   logic [ID_W-1:0]   act_id_in;
   logic [LANE_W-1:0] act_lane_ff;
   logic [LANE_W-1:0] act_lane_in;
   logic [7:0]        issued_ff;
   logic [7:0]        issued_in;
   logic [7:0]        served_ff;
   logic [7:0]        served_in;

   // Latched transaction
   logic              item_op_ff;
   logic [LANE_W-1:0] item_lane_ff;

   // Result register
   logic [2:0]        ev_ff;
   logic [ID_W-1:0]   id_ff;
   logic [LANE_W-1:0] lane_ff;
   logic              busy_ff;
   logic [7:0]        icnt_ff;
   logic [7:0]        scnt_ff;
   logic              done_ff;
   logic [2:0]        ev_c;
   logic [ID_W-1:0]   id_c;
   logic [LANE_W-1:0] lane_c;

   // Scan and store access
   logic              hit;
   logic [LANE_W-1:0] hit_lane;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [ID_W-1:0]   rd_data;

   assign csr_ready = 1'b1;

   // Circular scan from the scan pointer; the nearest non-empty lane wins
   always_comb begin
      logic [LANE_W:0] idx;
      hit      = 1'b0;
      hit_lane = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         idx = {1'b0, scan_ff} + (LANE_W + 1)'(k);
         if (idx >= (LANE_W + 1)'(LANES)) begin
            idx = idx - (LANE_W + 1)'(LANES);
         end
         if (fill_ff[idx[LANE_W-1:0]] != '0) begin
            hit      = 1'b1;
            hit_lane = idx[LANE_W-1:0];
         end
      end
   end

   assign stat.tick_grant = (req_op == OP_TICK) && !occ_ff && hit;

   // Store addresses: lane base plus ring pointer
   assign rd_addr = ADDR_W'(hit_lane) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(head_ff[hit_lane]);
   assign wr_addr = ADDR_W'(item_lane_ff) * ADDR_W'(FIFO_DEPTH)
                    + ADDR_W'(tail_ff[item_lane_ff]);

   fqca_ram #(
      .WIDTH (ID_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (issued_in),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Transaction execution
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      scan_in     = scan_ff;
      occ_in      = occ_ff;
      ticks_in    = ticks_ff;
      act_id_in   = act_id_ff;
      act_lane_in = act_lane_ff;
      issued_in   = issued_ff;
      served_in   = served_ff;
      wr_en       = 1'b0;
      ev_c        = EV_IDLE;
      id_c        = '0;
      lane_c      = '0;
      if (item_op_ff == OP_ARRIVAL) begin
         if (issued_ff >= id_limit_ff) begin
            ev_c = EV_REFUSED;
         end else begin
            issued_in = issued_ff + 8'd1;
            id_c      = issued_in;
            lane_c    = item_lane_ff;
            if (fill_ff[item_lane_ff] >= CNT_W'(FIFO_DEPTH)) begin
               ev_c = EV_DROP;
            end else begin
               ev_c                  = EV_QUEUED;
               wr_en                 = cmd.commit;
               tail_in[item_lane_ff] = ptr_next(tail_ff[item_lane_ff]);
               fill_in[item_lane_ff] = fill_ff[item_lane_ff] + CNT_W'(1);
            end
         end
      end else if (occ_ff) begin
         id_c   = act_id_ff;
         lane_c = act_lane_ff;
         if (ticks_ff <= 8'd1) begin
            ev_c      = EV_RELEASE;
            ticks_in  = '0;
            occ_in    = 1'b0;
            served_in = served_ff + 8'd1;
         end else begin
            ev_c     = EV_BUSY;
            ticks_in = ticks_ff - 8'd1;
         end
      end else if (hit) begin
         ev_c              = EV_GRANT;
         id_c              = rd_data;
         lane_c            = hit_lane;
         act_id_in         = rd_data;
         act_lane_in       = hit_lane;
         head_in[hit_lane] = ptr_next(head_ff[hit_lane]);
         fill_in[hit_lane] = fill_ff[hit_lane] - CNT_W'(1);
         scan_in           = hit_lane;
         occ_in            = 1'b1;
         ticks_in          = hold_ticks_ff;
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_RESET;
         id_limit_ff   <= LIMIT_RESET;
         for (int i = 0; i < LANES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         scan_ff     <= '0;
         occ_ff      <= 1'b0;
         ticks_ff    <= '0;
         act_id_ff   <= '0;
         act_lane_ff <= '0;
         issued_ff   <= '0;
         served_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_HOLD:  hold_ticks_ff <= csr_data;
               REG_LIMIT: id_limit_ff   <= csr_data;
               default:   ;
            endcase
         end
         if (cmd.commit) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            fill_ff     <= fill_in;
            scan_ff     <= scan_in;
            occ_ff      <= occ_in;
            ticks_ff    <= ticks_in;
            act_id_ff   <= act_id_in;
            act_lane_ff <= act_lane_in;
            issued_ff   <= issued_in;
            served_ff   <= served_in;
         end
      end
   end

   // Transaction latch and result payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_op_ff   <= req_op;
         item_lane_ff <= req_lane;
      end
      if (cmd.commit) begin
         ev_ff   <= ev_c;
         id_ff   <= id_c;
         lane_ff <= lane_c;
         busy_ff <= occ_in;
         icnt_ff <= issued_in;
         scnt_ff <= served_in;
         done_ff <= (served_in >= id_limit_ff);
      end
   end

   assign rsp_event_res    = ev_ff;
   assign rsp_req_id       = id_ff;
   assign rsp_req_lane     = lane_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_issued_count = icnt_ff;
   assign rsp_served_count = scnt_ff;
   assign rsp_done_flag    = done_ff;

endmodule
